// ----- rtl/core/assert_macros.svh -----
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every rising clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// ante in a cycle implies cons in the next one
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/gfmv_pkg.sv -----
package gfmv_pkg;

    localparam int CFG_DATA_W = 10;

    // configuration register indexes
    localparam logic CFG_ROW_WORDS    = 1'b0;
    localparam logic CFG_COLUMN_COUNT = 1'b1;

    localparam logic [9:0] ROW_WORDS_RST    = 10'd484;
    localparam logic [7:0] COLUMN_COUNT_RST = 8'd68;

    localparam logic [7:0] POLY_LOW    = 8'h1b;
    localparam int         QUEUE_DEPTH = 4;
    localparam int         IDX_OUT_W   = 9;

    typedef struct packed {
        logic first;     // first column: overwrite the accumulator
        logic emit;      // last column: word goes out
        logic last_row;  // final row group of the column
    } gfmv_flags_t;

    // Multiply each byte lane of w by g in GF(2^8) mod x^8+x^4+x^3+x+1.
    function automatic logic [31:0] gf_mul_lanes(input logic [31:0] w, input logic [7:0] g);
        logic [31:0] sum;
        logic [7:0]  pw;
        sum = '0;
        pw  = g;
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 4; j++) begin
                if (w[8*j+i]) begin
                    sum[8*j +: 8] = sum[8*j +: 8] ^ pw;
                end
            end
            pw = {pw[6:0], 1'b0} ^ (pw[7] ? POLY_LOW : 8'h00);
        end
        return sum;
    endfunction

endpackage

// ----- rtl/core/gfmv_front.sv -----
module gfmv_front #(
    parameter int MAX_ROW_WORDS = 512,
    parameter int MAX_COLUMNS   = 128,
    parameter int RIW           = 9
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [gfmv_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [31:0]                    s_mat_word,
    input  logic [7:0]                     s_coef,
    output logic                           push_valid,
    input  logic                           push_ready,
    output gfmv_pkg::gfmv_flags_t          push_flags,
    output logic [RIW-1:0]                 push_idx,
    output logic [31:0]                    push_prod
);

    localparam int RCW = ($clog2(MAX_ROW_WORDS + 1) > 10) ? $clog2(MAX_ROW_WORDS + 1) : 10;
    localparam int CCW = ($clog2(MAX_COLUMNS + 1) > 8) ? $clog2(MAX_COLUMNS + 1) : 8;
    localparam int CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    logic [9:0]     row_words_reg,    row_words_next;
    logic [7:0]     column_count_reg, column_count_next;
    logic [RIW-1:0] row_pos_reg,      row_pos_next;
    logic [CIW-1:0] col_pos_reg,      col_pos_next;

    logic [RCW-1:0] rw_ext, rows_eff;
    logic [CCW-1:0] cc_ext, cols_eff;
    logic           accept, last_row, last_col;

    // clamp sizes to 1..MAX
    always_comb begin
        rw_ext = RCW'(row_words_reg);
        cc_ext = CCW'(column_count_reg);
        if (rw_ext == '0) begin
            rows_eff = RCW'(1);
        end else if (rw_ext > RCW'(MAX_ROW_WORDS)) begin
            rows_eff = RCW'(MAX_ROW_WORDS);
        end else begin
            rows_eff = rw_ext;
        end
        if (cc_ext == '0) begin
            cols_eff = CCW'(1);
        end else if (cc_ext > CCW'(MAX_COLUMNS)) begin
            cols_eff = CCW'(MAX_COLUMNS);
        end else begin
            cols_eff = cc_ext;
        end
    end

    assign s_ready  = push_ready;
    assign accept   = s_valid && push_ready;
    assign last_row = (RCW'(row_pos_reg) == rows_eff - RCW'(1));
    assign last_col = (CCW'(col_pos_reg) == cols_eff - CCW'(1));

    assign push_valid          = s_valid;
    assign push_flags.first    = (col_pos_reg == '0);
    assign push_flags.emit     = last_col;
    assign push_flags.last_row = last_row;
    assign push_idx            = row_pos_reg;
    assign push_prod           = gfmv_pkg::gf_mul_lanes(s_mat_word, s_coef);

    always_comb begin
        row_words_next    = row_words_reg;
        column_count_next = column_count_reg;
        row_pos_next      = row_pos_reg;
        col_pos_next      = col_pos_reg;
        if (cfg_we) begin
            // any register write restarts the product
            row_pos_next = '0;
            col_pos_next = '0;
            case (cfg_index)
                gfmv_pkg::CFG_ROW_WORDS:    row_words_next    = cfg_wdata[9:0];
                gfmv_pkg::CFG_COLUMN_COUNT: column_count_next = cfg_wdata[7:0];
                default: ;
            endcase
        end else if (accept) begin
            if (last_row) begin
                row_pos_next = '0;
                col_pos_next = last_col ? '0 : col_pos_reg + CIW'(1);
            end else begin
                row_pos_next = row_pos_reg + RIW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_words_reg    <= gfmv_pkg::ROW_WORDS_RST;
            column_count_reg <= gfmv_pkg::COLUMN_COUNT_RST;
            row_pos_reg      <= '0;
            col_pos_reg      <= '0;
        end else begin
            row_words_reg    <= row_words_next;
            column_count_reg <= column_count_next;
            row_pos_reg      <= row_pos_next;
            col_pos_reg      <= col_pos_next;
        end
    end

endmodule

// ----- rtl/core/gfmv_queue.sv -----
module gfmv_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg,  count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != NW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + NW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/core/gfmv_back.sv -----
module gfmv_back #(
    parameter int MAX_ROW_WORDS = 512,
    parameter int RIW           = 9
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  gfmv_pkg::gfmv_flags_t q_flags,
    input  logic [RIW-1:0]        q_idx,
    input  logic [31:0]           q_prod,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [31:0]           m_result_word,
    output logic [gfmv_pkg::IDX_OUT_W-1:0] m_word_index,
    output logic                  m_last
);

    logic [31:0] acc_mem [MAX_ROW_WORDS];

    // read stage: request waits here for its accumulator word
    logic                  b1_valid_reg, b1_valid_next;
    gfmv_pkg::gfmv_flags_t b1_flags_reg;
    logic [RIW-1:0]        b1_idx_reg;
    logic [31:0]           b1_prod_reg;
    logic [31:0]           rdata_reg;
    logic                  byp_reg;
    logic [31:0]           byp_word_reg;

    logic                  m_valid_reg, m_valid_next;
    logic [31:0]           m_result_word_reg;
    logic [gfmv_pkg::IDX_OUT_W-1:0] m_word_index_reg;
    logic                  m_last_reg;

    logic        out_free, b1_fire, load;
    logic [31:0] old_word, b1_word, idx_wide;

    assign out_free = !m_valid_reg || m_ready;
    assign b1_fire  = b1_valid_reg && (!b1_flags_reg.emit || out_free);
    assign q_ready  = !b1_valid_reg || b1_fire;
    assign load     = q_valid && q_ready;

    // the write of the request leaving now is not yet seen by a read issued now
    assign old_word = byp_reg ? byp_word_reg : rdata_reg;
    assign b1_word  = b1_flags_reg.first ? b1_prod_reg : (old_word ^ b1_prod_reg);
    assign idx_wide = 32'(b1_idx_reg);

    always_ff @(posedge aclk) begin
        if (b1_fire) begin
            acc_mem[b1_idx_reg] <= b1_word;
        end
        if (load) begin
            rdata_reg <= acc_mem[q_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            b1_flags_reg <= q_flags;
            b1_idx_reg   <= q_idx;
            b1_prod_reg  <= q_prod;
            byp_reg      <= b1_fire && (b1_idx_reg == q_idx);
            byp_word_reg <= b1_word;
        end
        if (b1_fire && b1_flags_reg.emit) begin
            m_result_word_reg <= b1_word;
            m_word_index_reg  <= idx_wide[gfmv_pkg::IDX_OUT_W-1:0];
            m_last_reg        <= b1_flags_reg.last_row;
        end
    end

    always_comb begin
        b1_valid_next = b1_valid_reg;
        if (load) begin
            b1_valid_next = 1'b1;
        end else if (b1_fire) begin
            b1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (b1_fire && b1_flags_reg.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            b1_valid_reg <= b1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_word = m_result_word_reg;
    assign m_word_index  = m_word_index_reg;
    assign m_last        = m_last_reg;

endmodule

// ----- rtl/core/gf256_matrix_vector_product.sv -----
// GF(2^8) matrix-vector product (poly 0x11b), matrix streamed column by column, four row
// bytes per request plus that column's coefficient. Sustains one request per clock while the
// output is not stalled: each request is one read-modify-write of the single-write, single-read
// accumulator memory, and a back-to-back hit on the same word (row_words of one) is forwarded.
// Results come out only during the last column, one per request; each passes through the
// request queue, the read stage and the registered output. Other requests give none. Sizes are
// clamped to 1..MAX; a register write restarts the product.
// Accumulator contents are undefined after reset and need no clearing: the first column
// overwrites every word before it is read.
module gf256_matrix_vector_product #(
    parameter int MAX_ROW_WORDS = 512,
    parameter int MAX_COLUMNS   = 128
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [gfmv_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [31:0]                     s_mat_word,
    input  logic [7:0]                      s_coef,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [31:0]                     m_result_word,
    output logic [gfmv_pkg::IDX_OUT_W-1:0]  m_word_index,
    output logic                            m_last
);

    localparam int RIW = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;
    localparam int FW  = $bits(gfmv_pkg::gfmv_flags_t);
    localparam int QW  = FW + RIW + 32;

    logic                  f_valid, f_ready;
    gfmv_pkg::gfmv_flags_t f_flags;
    logic [RIW-1:0]        f_idx;
    logic [31:0]           f_prod;

    logic                  b_valid, b_ready;
    gfmv_pkg::gfmv_flags_t b_flags;
    logic [RIW-1:0]        b_idx;
    logic [31:0]           b_prod;
    logic [QW-1:0]         push_data, pop_data;

    gfmv_front #(
        .MAX_ROW_WORDS (MAX_ROW_WORDS),
        .MAX_COLUMNS   (MAX_COLUMNS),
        .RIW           (RIW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mat_word (s_mat_word),
        .s_coef     (s_coef),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_flags (f_flags),
        .push_idx   (f_idx),
        .push_prod  (f_prod)
    );

    assign push_data = {f_flags, f_idx, f_prod};

    gfmv_queue #(
        .W     (QW),
        .DEPTH (gfmv_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (push_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (pop_data)
    );

    assign b_flags = pop_data[QW-1 -: FW];
    assign b_idx   = pop_data[32 +: RIW];
    assign b_prod  = pop_data[31:0];

    gfmv_back #(
        .MAX_ROW_WORDS (MAX_ROW_WORDS),
        .RIW           (RIW)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (b_valid),
        .q_ready       (b_ready),
        .q_flags       (b_flags),
        .q_idx         (b_idx),
        .q_prod        (b_prod),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_word (m_result_word),
        .m_word_index  (m_word_index),
        .m_last        (m_last)
    );

endmodule

// ----- rtl/core/gfmv_checker.sv -----
`include "assert_macros.svh"

module gfmv_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_we,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [31:0]                    m_result_word,
    input logic [gfmv_pkg::IDX_OUT_W-1:0] m_word_index,
    input logic                           m_last
);

    logic [31:0]                    pending_reg;
    logic [gfmv_pkg::IDX_OUT_W-1:0] exp_idx_reg;
    logic                           s_acc, m_acc;

    assign s_acc = s_valid && s_ready;
    assign m_acc = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            exp_idx_reg <= '0;
        end else begin
            pending_reg <= pending_reg + 32'(s_acc) - 32'(m_acc);
            if (cfg_we) begin
                exp_idx_reg <= '0;
            end else if (m_acc) begin
                exp_idx_reg <= m_last ? '0 : exp_idx_reg + gfmv_pkg::IDX_OUT_W'(1);
            end
        end
    end

    // every shown result traces back to a request not yet answered
    `ASSERT_ALWAYS(a_result_has_source, aclk, aresetn, !m_valid || (pending_reg != '0),
        "result without a pending request")

    // words of one product leave in row order and restart after the flagged one
    `ASSERT_ALWAYS(a_index_order, aclk, aresetn, !m_valid || (m_word_index == exp_idx_reg),
        "result word index out of order")

    `ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_result_word) && $stable(m_word_index) && $stable(m_last),
        "stalled result changed")

endmodule

bind gf256_matrix_vector_product gfmv_checker u_gfmv_checker (.*);

// ----- sim/tb_gf256_matrix_vector_product.sv -----
module tb_gf256_matrix_vector_product;

    localparam int CLK_PERIOD    = 10;
    localparam int DRAIN_CYCLES  = 8;
    localparam int ITEM_TARGET   = 1750;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int ACC_DEPTH     = 512;
    localparam int COL_MAX       = 128;
    localparam logic [7:0] GF_REDUCE = 8'h1b;

    typedef enum logic [1:0] {
        STIM_WRITE,
        STIM_ITEM,
        STIM_CHECKED
    } stim_kind_t;

    typedef struct packed {
        stim_kind_t  kind;
        logic        reg_idx;
        logic [31:0] value;
        logic [7:0]  coef;
        logic [31:0] exp_word;
        logic [8:0]  exp_index;
        logic        exp_last;
    } stim_row_t;

    typedef struct packed {
        logic [31:0] word;
        logic [8:0]  index;
        logic        last;
    } product_word_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_we;
    logic                            cfg_index;
    logic [gfmv_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                            s_valid;
    logic                            s_ready;
    logic [31:0]                     s_mat_word;
    logic [7:0]                      s_coef;
    logic                            m_valid;
    logic                            m_ready;
    logic [31:0]                     m_result_word;
    logic [gfmv_pkg::IDX_OUT_W-1:0]  m_word_index;
    logic                            m_last;

    gf256_matrix_vector_product uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mat_word    (s_mat_word),
        .s_coef        (s_coef),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_word (m_result_word),
        .m_word_index  (m_word_index),
        .m_last        (m_last)
    );

    // product model state
    logic [31:0] acc_words [0:ACC_DEPTH-1];
    int          row_pos;
    int          col_pos;
    logic [9:0]  rows_reg;
    logic [7:0]  cols_reg;

    product_word_t pending_words [$];
    int            errors;
    bit            calm;
    int            random_items;

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("gf256_matrix_vector_product: mismatch");
        $finish;
    end

    // byte-lane GF(2^8) scaling, shift-and-add over the coefficient bits
    function automatic logic [31:0] gf_scale_word(input logic [31:0] w, input logic [7:0] g);
        logic [31:0] scaled;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  p;
        scaled = '0;
        for (int lane = 0; lane < 4; lane++) begin
            a = w[8*lane +: 8];
            b = g;
            p = '0;
            for (int k = 0; k < 8; k++) begin
                if (b[0]) begin
                    p = p ^ a;
                end
                a = {a[6:0], 1'b0} ^ (a[7] ? GF_REDUCE : 8'h00);
                b = b >> 1;
            end
            scaled[8*lane +: 8] = p;
        end
        return scaled;
    endfunction

    function automatic int active_rows();
        if (rows_reg == 0) return 1;
        if (rows_reg > ACC_DEPTH) return ACC_DEPTH;
        return int'(rows_reg);
    endfunction

    function automatic int active_cols();
        if (cols_reg == 0) return 1;
        if (cols_reg > COL_MAX) return COL_MAX;
        return int'(cols_reg);
    endfunction

    task automatic apply_reg(input logic idx, input logic [9:0] v);
        if (idx == gfmv_pkg::CFG_ROW_WORDS) begin
            rows_reg = v;
        end else begin
            cols_reg = v[7:0];
        end
        row_pos = 0;
        col_pos = 0;
    endtask

    task automatic accumulate(input logic [31:0] mat, input logic [7:0] coef,
                              output bit emit, output product_word_t res);
        int          nrows;
        int          ncols;
        logic [31:0] prod;
        logic [31:0] word;
        nrows = active_rows();
        ncols = active_cols();
        if (row_pos >= nrows) row_pos = 0;
        if (col_pos >= ncols) col_pos = 0;
        prod = gf_scale_word(mat, coef);
        word = (col_pos == 0) ? prod : (acc_words[row_pos] ^ prod);
        acc_words[row_pos] = word;
        emit = (col_pos == ncols - 1);
        res.word  = word;
        res.index = row_pos[8:0];
        res.last  = (row_pos == nrows - 1);
        row_pos++;
        if (row_pos >= nrows) begin
            row_pos = 0;
            col_pos++;
            if (col_pos >= ncols) col_pos = 0;
        end
    endtask

    function automatic stim_row_t cfg_row(input logic idx, input int v);
        cfg_row = '0;
        cfg_row.kind    = STIM_WRITE;
        cfg_row.reg_idx = idx;
        cfg_row.value   = 32'(v);
    endfunction

    function automatic stim_row_t data_row(input logic [31:0] mat, input logic [7:0] coef);
        data_row = '0;
        data_row.kind  = STIM_ITEM;
        data_row.value = mat;
        data_row.coef  = coef;
    endfunction

    function automatic stim_row_t known_row(input logic [31:0] mat, input logic [7:0] coef,
                                            input logic [31:0] word, input int index,
                                            input logic last);
        known_row = '0;
        known_row.kind      = STIM_CHECKED;
        known_row.value     = mat;
        known_row.coef      = coef;
        known_row.exp_word  = word;
        known_row.exp_index = 9'(index);
        known_row.exp_last  = last;
    endfunction

    function automatic logic [7:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // present one request and hold it until taken
    task automatic offer_item(input logic [31:0] mat, input logic [7:0] coef,
                              input bit typed, input product_word_t typed_res);
        int            gap;
        bit            emit;
        product_word_t res;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_mat_word <= mat;
        s_coef     <= coef;
        do @(posedge aclk); while (!s_ready);
        accumulate(mat, coef, emit, res);
        if (emit) begin
            pending_words.push_back(typed ? typed_res : res);
        end
    endtask

    // registers only change with nothing in flight
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [9:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        apply_reg(idx, v);
    endtask

    task automatic feed_random(input int n);
        repeat (n) begin
            offer_item($urandom, pick_coef(), 1'b0, '0);
        end
        random_items += n;
    endtask

    // stall bursts on the result side
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        product_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: result expected none actual word %h index %0d last %b",
                         $time, m_result_word, m_word_index, m_last);
                errors++;
            end else begin
                e = pending_words.pop_front();
                if (m_result_word !== e.word) begin
                    $display("%0t: result_word expected %h actual %h",
                             $time, e.word, m_result_word);
                    errors++;
                end
                if (m_word_index !== e.index) begin
                    $display("%0t: word_index expected %0d actual %0d",
                             $time, e.index, m_word_index);
                    errors++;
                end
                if (m_last !== e.last) begin
                    $display("%0t: last expected %b actual %b", $time, e.last, m_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        stim_row_t     directed_tbl [$];
        product_word_t typed_res;
        logic [9:0]    rv;
        logic [9:0]    cv;
        bit            wide_rows;
        int            span;
        int            n;

        errors       = 0;
        calm         = 1'b0;
        random_items = 0;
        for (int i = 0; i < ACC_DEPTH; i++) acc_words[i] = '0;
        rows_reg = gfmv_pkg::ROW_WORDS_RST;
        cols_reg = gfmv_pkg::COLUMN_COUNT_RST;
        row_pos  = 0;
        col_pos  = 0;

        aresetn    <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= gfmv_pkg::CFG_ROW_WORDS;
        cfg_wdata  <= '0;
        s_valid    <= 1'b0;
        s_mat_word <= '0;
        s_coef     <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        directed_tbl = '{
            // one word, one column: every request is a finished product
            cfg_row(gfmv_pkg::CFG_ROW_WORDS, 1),
            cfg_row(gfmv_pkg::CFG_COLUMN_COUNT, 1),
            known_row(32'hffffffff, 8'h01, 32'hffffffff, 0, 1'b1),
            known_row(32'h00000000, 8'hff, 32'h00000000, 0, 1'b1),
            known_row(32'hffffffff, 8'h00, 32'h00000000, 0, 1'b1),
            known_row(32'h80808080, 8'h02, 32'h1b1b1b1b, 0, 1'b1),
            known_row(32'h01020408, 8'h01, 32'h01020408, 0, 1'b1),
            data_row(32'h12345678, 8'hff),
            data_row(32'hdeadbeef, 8'h53),
            // zero columns clamps to one
            cfg_row(gfmv_pkg::CFG_COLUMN_COUNT, 0),
            known_row(32'ha5a5a5a5, 8'h01, 32'ha5a5a5a5, 0, 1'b1),
            // single word, three columns: back-to-back hits on one entry
            cfg_row(gfmv_pkg::CFG_COLUMN_COUNT, 3),
            data_row(32'h0f0f0f0f, 8'h01),
            data_row(32'hf0f0f0f0, 8'h01),
            data_row(32'h11223344, 8'h87),
            data_row(32'hffffffff, 8'hff),
            data_row(32'h80000001, 8'h80),
            data_row(32'h7f7f7f7f, 8'h03),
            // zero rows clamps to one
            cfg_row(gfmv_pkg::CFG_ROW_WORDS, 0),
            data_row(32'hcafef00d, 8'h1b),
            data_row(32'h00ff00ff, 8'he5),
            data_row(32'hff00ff00, 8'h02),
            // a write in mid-product starts over
            cfg_row(gfmv_pkg::CFG_ROW_WORDS, 2),
            cfg_row(gfmv_pkg::CFG_COLUMN_COUNT, 2),
            data_row(32'h55555555, 8'h09),
            data_row(32'haaaaaaaa, 8'h0d),
            cfg_row(gfmv_pkg::CFG_COLUMN_COUNT, 2),
            data_row(32'h01010101, 8'h02),
            data_row(32'h02020202, 8'h04),
            data_row(32'h04040404, 8'h08),
            data_row(32'h08080808, 8'h10)
        };

        foreach (directed_tbl[i]) begin
            case (directed_tbl[i].kind)
                STIM_WRITE: begin
                    settle();
                    write_reg(directed_tbl[i].reg_idx, directed_tbl[i].value[9:0]);
                end
                STIM_ITEM: begin
                    offer_item(directed_tbl[i].value, directed_tbl[i].coef, 1'b0, '0);
                end
                default: begin
                    typed_res.word  = directed_tbl[i].exp_word;
                    typed_res.index = directed_tbl[i].exp_index;
                    typed_res.last  = directed_tbl[i].exp_last;
                    offer_item(directed_tbl[i].value, directed_tbl[i].coef, 1'b1, typed_res);
                end
            endcase
        end

        // deepest column (row count clamps to the maximum), one column
        settle();
        write_reg(gfmv_pkg::CFG_ROW_WORDS, 10'h3ff);
        write_reg(gfmv_pkg::CFG_COLUMN_COUNT, 10'd1);
        feed_random(530);

        // widest product (column count clamps to the maximum), one word per column
        settle();
        write_reg(gfmv_pkg::CFG_COLUMN_COUNT, 10'h3ff);
        write_reg(gfmv_pkg::CFG_ROW_WORDS, 10'd1);
        feed_random(2 * COL_MAX);

        while (random_items < ITEM_TARGET) begin
            settle();
            calm = (random_items > ITEM_TARGET - 200) || ($urandom_range(0, 3) == 0);
            wide_rows = 1'b0;
            case ($urandom_range(0, 9))
                0: rv = 10'd0;
                1: begin
                    rv = 10'($urandom_range(0, 1023));
                    wide_rows = 1'b1;
                end
                default: rv = 10'($urandom_range(1, 8));
            endcase
            if (wide_rows) begin
                cv = {2'($urandom_range(0, 3)), 8'($urandom_range(0, 1))};
            end else if ($urandom_range(0, 7) == 0) begin
                cv = {2'($urandom_range(0, 3)), 8'd0};
            end else begin
                cv = {2'($urandom_range(0, 3)), 8'($urandom_range(1, 4))};
            end
            if (!wide_rows && $urandom_range(0, 4) == 0) begin
                // touch only one register, the other keeps its value
                if ($urandom_range(0, 1) == 0) begin
                    write_reg(gfmv_pkg::CFG_ROW_WORDS, rv);
                end else begin
                    write_reg(gfmv_pkg::CFG_COLUMN_COUNT, cv);
                end
            end else if ($urandom_range(0, 1) == 0) begin
                write_reg(gfmv_pkg::CFG_ROW_WORDS, rv);
                write_reg(gfmv_pkg::CFG_COLUMN_COUNT, cv);
            end else begin
                write_reg(gfmv_pkg::CFG_COLUMN_COUNT, cv);
                write_reg(gfmv_pkg::CFG_ROW_WORDS, rv);
            end
            span = active_rows() * active_cols();
            if (span > 64) begin
                n = $urandom_range(1, 64);
            end else if ($urandom_range(0, 6) == 0) begin
                // any length, possibly cut short; the next write restarts the product
                n = $urandom_range(1, 2 * span);
            end else begin
                n = span * $urandom_range(1, 3);
            end
            feed_random(n);
        end

        settle();
        if (errors == 0) begin
            $display("gf256_matrix_vector_product: match");
        end else begin
            $display("gf256_matrix_vector_product: mismatch");
        end
        $finish;
    end

endmodule
